[rtl/cbf_pkg.sv]
// Shared types and constants for the comment blanking filter.
package cbf_pkg;

	localparam int unsigned CharW = 16;

	typedef logic [CharW-1:0] char_t;

	// Input action codes.
	localparam logic [1:0] ACT_CHAR  = 2'd0;
	localparam logic [1:0] ACT_EOL   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// Characters the scanner reacts to.
	localparam char_t CH_NUL   = 16'h0000;
	localparam char_t CH_SLASH = 16'h002F;
	localparam char_t CH_STAR  = 16'h002A;
	localparam char_t CH_QUOTE = 16'h0022;
	localparam char_t CH_HASH  = 16'h0023;
	localparam char_t CH_SPACE = 16'h0020;

	// One queue entry: the one or two results caused by one input word.
	// When two is set, c0 goes first and c1 second. line_end applies to the
	// final result of the entry.
	typedef struct packed {
		logic  two;
		logic  line_end;
		char_t c0;
		char_t c1;
	} cbf_entry_t;

	// Handshake between the queue and the back end.
	typedef struct packed {
		logic pop;
	} cbf_qctl_t;

endpackage

[rtl/cbf_channels.sv]
// Valid/ready channel interfaces for input words and result words.
interface cbf_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	cbf_pkg::char_t    ch;

	modport source (output valid, output action, output ch, input ready);
	modport sink   (input valid, input action, input ch, output ready);
endinterface

interface cbf_out_if;
	logic              valid;
	logic              ready;
	cbf_pkg::char_t    out_char;
	logic              is_line_end;
	logic              last;

	modport source (output valid, output out_char, output is_line_end, output last,
		input ready);
	modport sink   (input valid, input out_char, input is_line_end, input last,
		output ready);
endinterface

[rtl/cbf_front.sv]
// Front end: accepts input words, tracks the scan state and classifies each word.
module cbf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	cbf_in_if.sink             items,
	input  logic               full,
	output logic               push,
	output cbf_pkg::cbf_entry_t push_data
);

	localparam logic [1:0] MODE_PLAIN   = 2'd0;
	localparam logic [1:0] MODE_QUOTE   = 2'd1;
	localparam logic [1:0] MODE_COMMENT = 2'd2;

	logic       style_q;
	logic [1:0] mode_q;
	logic       slash_q;
	logic       star_q;
	logic       dropped_q;

	logic [1:0] mode_d;
	logic       slash_d;
	logic       star_d;
	logic       dropped_d;

	// A result is made of an optional held character followed by an optional
	// main character.
	logic           held_v;
	cbf_pkg::char_t held_c;
	logic           main_v;
	cbf_pkg::char_t main_c;
	logic           main_eol;
	logic           flush_v;
	cbf_pkg::char_t flush_c;
	logic           accept;

	assign items.ready = !full;
	assign accept      = items.valid && items.ready;

	assign flush_v = slash_q || star_q;
	assign flush_c = slash_q ? cbf_pkg::CH_SLASH : cbf_pkg::CH_SPACE;

	always_comb begin
		mode_d    = mode_q;
		slash_d   = slash_q;
		star_d    = star_q;
		dropped_d = dropped_q;
		held_v    = 1'b0;
		held_c    = cbf_pkg::CH_SPACE;
		main_v    = 1'b0;
		main_c    = cbf_pkg::CH_SPACE;
		main_eol  = 1'b0;
		unique case (items.action)
			cbf_pkg::ACT_CHAR: begin
				if (!dropped_q) begin
					if (!style_q && slash_q && items.ch == cbf_pkg::CH_SLASH) begin
						slash_d   = 1'b0;
						dropped_d = 1'b1;
					end else if (!style_q && slash_q && items.ch == cbf_pkg::CH_STAR) begin
						slash_d = 1'b0;
						mode_d  = MODE_COMMENT;
						held_v  = 1'b1;
						main_v  = 1'b1;
					end else if (!style_q && !slash_q && star_q &&
							items.ch == cbf_pkg::CH_SLASH) begin
						star_d = 1'b0;
						mode_d = MODE_PLAIN;
						held_v = 1'b1;
						main_v = 1'b1;
					end else begin
						held_v  = flush_v;
						held_c  = flush_c;
						slash_d = 1'b0;
						star_d  = 1'b0;
						if (items.ch == cbf_pkg::CH_NUL) begin
							dropped_d = 1'b1;
						end else if (style_q) begin
							if (items.ch == cbf_pkg::CH_HASH) begin
								dropped_d = 1'b1;
							end else begin
								main_v = 1'b1;
								main_c = items.ch;
							end
						end else begin
							case (mode_q)
								MODE_QUOTE: begin
									if (items.ch == cbf_pkg::CH_QUOTE) begin
										mode_d = MODE_PLAIN;
									end
									main_v = 1'b1;
								end
								MODE_COMMENT: begin
									if (items.ch == cbf_pkg::CH_STAR) begin
										star_d = 1'b1;
									end else begin
										main_v = 1'b1;
									end
								end
								default: begin
									if (items.ch == cbf_pkg::CH_QUOTE) begin
										mode_d = MODE_QUOTE;
										main_v = 1'b1;
									end else if (items.ch == cbf_pkg::CH_SLASH) begin
										slash_d = 1'b1;
									end else if (items.ch == cbf_pkg::CH_HASH) begin
										dropped_d = 1'b1;
									end else begin
										main_v = 1'b1;
										main_c = items.ch;
									end
								end
							endcase
						end
					end
				end
			end
			cbf_pkg::ACT_EOL: begin
				held_v    = flush_v;
				held_c    = flush_c;
				slash_d   = 1'b0;
				star_d    = 1'b0;
				dropped_d = 1'b0;
				main_v    = 1'b1;
				main_c    = cbf_pkg::CH_NUL;
				main_eol  = 1'b1;
			end
			cbf_pkg::ACT_CLEAR: begin
				mode_d    = MODE_PLAIN;
				slash_d   = 1'b0;
				star_d    = 1'b0;
				dropped_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		push_data.two      = held_v && main_v;
		push_data.line_end = main_eol;
		push_data.c0       = held_v ? held_c : main_c;
		push_data.c1       = main_c;
	end

	assign push = accept && (held_v || main_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			style_q   <= 1'b0;
			mode_q    <= MODE_PLAIN;
			slash_q   <= 1'b0;
			star_q    <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				style_q <= cfg_wdata;
			end
			if (accept) begin
				mode_q    <= mode_d;
				slash_q   <= slash_d;
				star_q    <= star_d;
				dropped_q <= dropped_d;
			end
		end
	end

	a_held_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(slash_q && star_q))
		else $error("slash and star held at once");

	a_mode_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3)
		else $error("scan mode reached an unused code");

	a_dropped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && dropped_q && items.action == cbf_pkg::ACT_CHAR |-> !push)
		else $error("character produced output while the line is dropped");

endmodule

[rtl/cbf_queue.sv]
// Short queue of classified entries between the front and back ends.
module cbf_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cbf_pkg::cbf_entry_t push_data,
	output logic                full,
	input  cbf_pkg::cbf_qctl_t  ctl_in,
	output logic                empty,
	output cbf_pkg::cbf_entry_t pop_data
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	cbf_pkg::cbf_entry_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = count_q == CntW'(DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = ctl_in.pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/cbf_back.sv]
// Back end: splits queue entries into result words and drives the output register.
module cbf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  cbf_pkg::cbf_entry_t pop_data,
	output cbf_pkg::cbf_qctl_t  ctl_out,
	cbf_out_if.source           results
);

	logic           out_valid_q;
	cbf_pkg::char_t out_char_q;
	logic           out_eol_q;
	logic           out_last_q;

	// Second word of a two-word entry, waiting behind the first.
	logic           sec_valid_q;
	cbf_pkg::char_t sec_char_q;
	logic           sec_eol_q;

	logic out_free;
	logic pop;

	assign out_free    = !out_valid_q || results.ready;
	assign pop         = out_free && !sec_valid_q && !empty;
	assign ctl_out.pop = pop;

	assign results.valid       = out_valid_q;
	assign results.out_char    = out_char_q;
	assign results.is_line_end = out_eol_q;
	assign results.last        = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (out_free) begin
			if (sec_valid_q) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= 1'b0;
			end else begin
				out_valid_q <= !empty;
				sec_valid_q <= !empty && pop_data.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (sec_valid_q) begin
				out_char_q <= sec_char_q;
				out_eol_q  <= sec_eol_q;
				out_last_q <= 1'b1;
			end else if (pop) begin
				out_char_q <= pop_data.c0;
				out_eol_q  <= pop_data.line_end && !pop_data.two;
				out_last_q <= !pop_data.two;
				sec_char_q <= pop_data.c1;
				sec_eol_q  <= pop_data.line_end;
			end
		end
	end

	a_second_behind_first: assert property (@(posedge clk) disable iff (!arst_n)
		sec_valid_q |-> out_valid_q && !out_last_q)
		else $error("second word waits without a first word in front");

	a_eol_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_eol_q |-> out_last_q)
		else $error("line end word is not the last of its input word");

	a_no_pop_with_second: assert property (@(posedge clk) disable iff (!arst_n)
		sec_valid_q |-> !pop)
		else $error("queue popped while a second word is still pending");

endmodule

[rtl/comment_blanking_filter.sv]
// Comment blanking filter: front end, entry queue and back end.
//
// Input words arrive on the items channel (valid/ready) carrying an action and
// a 16-bit character; result words leave on the results channel with the
// character, a line-end flag and a flag marking the last word caused by an
// input word. An input word causes none, one or two result words.
//
// The front end takes one input word per cycle while the queue has room and
// updates the scan state in that cycle. The first result word of an input word
// passes through the queue and then the output register before it is presented
// on the results channel. The back end sends one result word per cycle while the
// receiver is ready, so a word with two results holds the output for both words;
// the queue of QUEUE_DEPTH entries absorbs short runs of these, and a long run
// of them fills the queue and slows the input. When the receiver stalls, the
// output register holds its word, the queue fills and then items.ready falls.
// Reset clears the scan state, the style register (C-style), the queue and the
// output register. The user writes the style register through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
module comment_blanking_filter #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	cbf_in_if.sink     items,
	cbf_out_if.source  results
);

	logic                full;
	logic                push;
	logic                empty;
	cbf_pkg::cbf_entry_t push_data;
	cbf_pkg::cbf_entry_t pop_data;
	cbf_pkg::cbf_qctl_t  qctl;

	cbf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	cbf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.ctl_in    (qctl),
		.empty     (empty),
		.pop_data  (pop_data)
	);

	cbf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop_data (pop_data),
		.ctl_out  (qctl),
		.results  (results)
	);

endmodule

[tb/cbf_result_checker.sv]
// Watches both channels of the comment blanking filter and checks the result words.
module cbf_result_checker (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  logic  cfg_wdata,
	cbf_in_if     items,
	cbf_out_if    results,
	output int    fail_count,
	output int    words_due,
	output int    words_checked
);

	typedef enum logic [1:0] {
		SCAN_TEXT    = 2'd0,
		SCAN_QUOTE   = 2'd1,
		SCAN_COMMENT = 2'd2
	} scan_t;

	typedef struct packed {
		cbf_pkg::char_t ch;
		logic           eol;
		logic           last;
	} blank_word_t;

	scan_t       scan;
	logic        held_slash;
	logic        held_star;
	logic        line_skip;
	logic        style_hash;
	blank_word_t blanked_due[$];
	blank_word_t word_out[$];
	int          n_fail;
	int          n_checked;

	task automatic emit(input cbf_pkg::char_t c, input logic eol);
		blank_word_t w;
		w.ch   = c;
		w.eol  = eol;
		w.last = 1'b0;
		word_out.push_back(w);
	endtask

	// A held slash comes out as itself; a held star inside a comment is blanked.
	task automatic release_held();
		if (held_slash)
			emit(cbf_pkg::CH_SLASH, 1'b0);
		else if (held_star)
			emit(cbf_pkg::CH_SPACE, 1'b0);
		held_slash = 1'b0;
		held_star  = 1'b0;
	endtask

	task automatic scan_char(input cbf_pkg::char_t c);
		if (line_skip)
			return;
		if (!style_hash) begin
			if (held_slash) begin
				if (c == cbf_pkg::CH_SLASH) begin
					held_slash = 1'b0;
					line_skip  = 1'b1;
					return;
				end
				if (c == cbf_pkg::CH_STAR) begin
					held_slash = 1'b0;
					scan       = SCAN_COMMENT;
					emit(cbf_pkg::CH_SPACE, 1'b0);
					emit(cbf_pkg::CH_SPACE, 1'b0);
					return;
				end
			end else if (held_star && c == cbf_pkg::CH_SLASH) begin
				held_star = 1'b0;
				scan      = SCAN_TEXT;
				emit(cbf_pkg::CH_SPACE, 1'b0);
				emit(cbf_pkg::CH_SPACE, 1'b0);
				return;
			end
		end
		release_held();
		if (c == cbf_pkg::CH_NUL) begin
			line_skip = 1'b1;
			return;
		end
		if (style_hash) begin
			if (c == cbf_pkg::CH_HASH)
				line_skip = 1'b1;
			else
				emit(c, 1'b0);
			return;
		end
		case (scan)
			SCAN_QUOTE: begin
				if (c == cbf_pkg::CH_QUOTE)
					scan = SCAN_TEXT;
				emit(cbf_pkg::CH_SPACE, 1'b0);
			end
			SCAN_COMMENT: begin
				if (c == cbf_pkg::CH_STAR)
					held_star = 1'b1;
				else
					emit(cbf_pkg::CH_SPACE, 1'b0);
			end
			default: begin
				if (c == cbf_pkg::CH_QUOTE) begin
					scan = SCAN_QUOTE;
					emit(cbf_pkg::CH_SPACE, 1'b0);
				end else if (c == cbf_pkg::CH_SLASH) begin
					held_slash = 1'b1;
				end else if (c == cbf_pkg::CH_HASH) begin
					line_skip = 1'b1;
				end else begin
					emit(c, 1'b0);
				end
			end
		endcase
	endtask

	task automatic filter_word(input logic [1:0] act, input cbf_pkg::char_t c);
		word_out.delete();
		case (act)
			cbf_pkg::ACT_CHAR: scan_char(c);
			cbf_pkg::ACT_EOL: begin
				release_held();
				line_skip = 1'b0;
				emit(cbf_pkg::CH_NUL, 1'b1);
			end
			cbf_pkg::ACT_CLEAR: begin
				scan       = SCAN_TEXT;
				held_slash = 1'b0;
				held_star  = 1'b0;
				line_skip  = 1'b0;
			end
			default: ;
		endcase
		if (word_out.size() > 0)
			word_out[word_out.size()-1].last = 1'b1;
		foreach (word_out[i])
			blanked_due.push_back(word_out[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		blank_word_t got;
		blank_word_t want;
		if (!arst_n) begin
			scan       = SCAN_TEXT;
			held_slash = 1'b0;
			held_star  = 1'b0;
			line_skip  = 1'b0;
			style_hash = 1'b0;
			blanked_due.delete();
			n_fail     = 0;
			n_checked  = 0;
			fail_count    <= 0;
			words_due     <= 0;
			words_checked <= 0;
		end else begin
			if (results.valid && results.ready) begin
				got.ch   = results.out_char;
				got.eol  = results.is_line_end;
				got.last = results.last;
				if (blanked_due.size() == 0) begin
					$display("%0t: unexpected word: char %h eol %b last %b", $time,
						got.ch, got.eol, got.last);
					n_fail++;
				end else begin
					want = blanked_due.pop_front();
					n_checked++;
					if (got.ch !== want.ch || got.eol !== want.eol ||
							got.last !== want.last) begin
						$display("%0t: mismatch: expected char %h eol %b last %b,",
							$time, want.ch, want.eol, want.last,
							" got char %h eol %b last %b", got.ch, got.eol, got.last);
						n_fail++;
					end
				end
			end
			if (items.valid && items.ready)
				filter_word(items.action, items.ch);
			if (cfg_we)
				style_hash = cfg_wdata;
			fail_count    <= n_fail;
			words_due     <= blanked_due.size();
			words_checked <= n_checked;
		end
	end

endmodule

[tb/tb_comment_blanking_filter.sv]
// Top of the comment blanking filter testbench: clock, reset, stimulus and verdict.
module tb_comment_blanking_filter;

	localparam logic [1:0] ACT_IGNORED = 2'd3;
	localparam logic       STYLE_C     = 1'b0;
	localparam logic       STYLE_HASH  = 1'b1;
	localparam int         LIMIT_CYCLES = 300000;
	localparam int         SETTLE_CYCLES = 12;
	localparam int         RANDOM_PHASES = 8;
	localparam int         PHASE_WORDS   = 250;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   fail_count;
	int   words_due;
	int   words_checked;
	int   words_sent;
	int   cycle_count = 0;
	logic in_idle_on;
	logic out_idle_on;

	cbf_in_if  in_ch();
	cbf_out_if out_ch();

	comment_blanking_filter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.items    (in_ch),
		.results  (out_ch)
	);

	cbf_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.items        (in_ch),
		.results      (out_ch),
		.fail_count   (fail_count),
		.words_due    (words_due),
		.words_checked(words_checked)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_comment_blanking_filter NOT OK");
			$finish;
		end
	end

	// The receiver stalls in short random bursts while its idling is switched on.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_idle_on && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	task automatic send_word(input logic [1:0] act, input cbf_pkg::char_t c);
		if (in_idle_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.action <= act;
		in_ch.ch     <= c;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		if (act != ACT_IGNORED)
			words_sent++;
	endtask

	task automatic send_ch(input cbf_pkg::char_t c);
		send_word(cbf_pkg::ACT_CHAR, c);
	endtask

	task automatic send_eol();
		send_word(cbf_pkg::ACT_EOL, cbf_pkg::char_t'($urandom));
	endtask

	// A held character gives no word of its own, so the block is left to settle
	// after the last expected word before anything is changed.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_style(input logic style);
		cfg_we    <= 1'b1;
		cfg_wdata <= style;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic cbf_pkg::char_t pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 14) return cbf_pkg::CH_SLASH;
		if (r < 26) return cbf_pkg::CH_STAR;
		if (r < 34) return cbf_pkg::CH_QUOTE;
		if (r < 39) return cbf_pkg::CH_HASH;
		if (r < 41) return cbf_pkg::CH_NUL;
		if (r < 48) return cbf_pkg::char_t'($urandom);
		if (r < 53) return cbf_pkg::CH_SPACE;
		return cbf_pkg::char_t'(16'h0061 + $urandom_range(0, 25));
	endfunction

	task automatic send_random_line();
		int len;
		int r;
		len = $urandom_range(0, 14);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				send_word(cbf_pkg::ACT_CLEAR, cbf_pkg::char_t'($urandom));
			else if (r < 3)
				send_word(ACT_IGNORED, cbf_pkg::char_t'($urandom));
			else
				send_ch(pick_char());
		end
		send_eol();
	endtask

	initial begin
		int phase_start;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.action = cbf_pkg::ACT_CHAR;
		in_ch.ch     = cbf_pkg::CH_NUL;
		in_idle_on   = 1'b1;
		out_idle_on  = 1'b1;
		words_sent   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_style(STYLE_C);

		// C-style: extremes, lone slash, comment across a line end, quotes,
		// held characters at a line end and before a NUL, line drops, clear.
		send_ch(16'h0041);
		send_ch(16'hFFFF);
		send_ch(cbf_pkg::CH_SLASH);
		send_ch(16'h0078);
		send_ch(cbf_pkg::CH_SLASH);
		send_ch(cbf_pkg::CH_STAR);
		send_ch(cbf_pkg::CH_STAR);
		send_eol();
		send_ch(cbf_pkg::CH_STAR);
		send_ch(cbf_pkg::CH_SLASH);
		send_ch(cbf_pkg::CH_QUOTE);
		send_eol();
		send_ch(cbf_pkg::CH_QUOTE);
		send_ch(cbf_pkg::CH_SLASH);
		send_eol();
		send_ch(cbf_pkg::CH_SLASH);
		send_ch(cbf_pkg::CH_NUL);
		send_eol();
		send_ch(cbf_pkg::CH_SLASH);
		send_ch(cbf_pkg::CH_SLASH);
		send_ch(cbf_pkg::CH_HASH);
		send_eol();
		send_word(cbf_pkg::ACT_CLEAR, cbf_pkg::CH_NUL);
		send_word(ACT_IGNORED, 16'hFFFF);
		// A slash still held when the style changes to hash mode.
		send_ch(cbf_pkg::CH_SLASH);
		drain();
		write_style(STYLE_HASH);
		send_ch(16'h0078);
		send_ch(cbf_pkg::CH_HASH);
		send_eol();
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_style((p % 3 == 1) ? STYLE_HASH : STYLE_C);
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS) begin
				in_idle_on  = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 5) != 0);
				out_idle_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 5) != 0);
				send_random_line();
			end
			drain();
		end

		while (words_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d input words in C-style and hash mode, with idling on both sides.",
			words_sent);
		$display("%0d result words were checked; %0d failures.", words_checked, fail_count);
		if (fail_count == 0 && words_due == 0) begin
			$display("tb_comment_blanking_filter OK");
		end else begin
			$display("tb_comment_blanking_filter NOT OK");
		end
		$finish;
	end

endmodule

[files.f]
rtl/cbf_pkg.sv
rtl/cbf_channels.sv
rtl/cbf_front.sv
rtl/cbf_queue.sv
rtl/cbf_back.sv
rtl/comment_blanking_filter.sv
tb/cbf_result_checker.sv
tb/tb_comment_blanking_filter.sv
